@@ design/cao_pkg.sv @@
// Shared constants, types and format decoding for the cursor alpha overlay.
package cao_pkg;

   localparam int CURSOR_SIDE = 64;
   localparam int STORE_DEPTH = CURSOR_SIDE * CURSOR_SIDE;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;
   localparam int COORD_W     = 13;
   localparam int DIM_W       = 7;
   localparam int FMT_W       = 3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_BLEND = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_LEFT_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP_Y  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FORMAT = 3'd4;

   localparam logic [FMT_W-1:0] FMT_XRGB_A = 3'd0;
   localparam logic [FMT_W-1:0] FMT_XBGR_A = 3'd1;
   localparam logic [FMT_W-1:0] FMT_XRGB_B = 3'd2;
   localparam logic [FMT_W-1:0] FMT_XBGR_B = 3'd3;
   localparam logic [FMT_W-1:0] FMT_RGBX   = 3'd4;
   localparam logic [FMT_W-1:0] FMT_BGRX   = 3'd5;
   localparam logic [FMT_W-1:0] FMT_PASS   = 3'd6;
   localparam logic [FMT_W-1:0] FMT_RSVD   = 3'd7;

   typedef struct packed {
      logic       ok;
      logic [1:0] ro;
      logic [1:0] go;
      logic [1:0] bo;
   } chan_map_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] ro;
      logic [1:0] go;
      logic [1:0] bo;
   } blend_ctl_type;

   function automatic chan_map_type decode_format(input logic [FMT_W-1:0] fmt);
      chan_map_type m;
      m = '0;
      case (fmt)
         FMT_XRGB_A, FMT_XRGB_B: begin
            m.ok = 1'b1; m.ro = 2'd2; m.go = 2'd1; m.bo = 2'd0;
         end
         FMT_XBGR_A, FMT_XBGR_B: begin
            m.ok = 1'b1; m.ro = 2'd0; m.go = 2'd1; m.bo = 2'd2;
         end
         FMT_RGBX: begin
            m.ok = 1'b1; m.ro = 2'd3; m.go = 2'd2; m.bo = 2'd1;
         end
         FMT_BGRX: begin
            m.ok = 1'b1; m.ro = 2'd1; m.go = 2'd2; m.bo = 2'd3;
         end
         default: begin
            m = '0;
         end
      endcase
      return m;
   endfunction

endpackage

@@ design/cao_blend.sv @@
// Two-stage channel blend: multiply by inverse alpha, then divide by 255 and add cursor.
module cao_blend (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  cao_pkg::blend_ctl_type in_ctl,
   input  logic [31:0]            in_img,
   input  logic [31:0]            in_cur,
   output logic                   out_valid,
   output logic                   out_hit,
   output logic [31:0]            out_pixel
);
   import cao_pkg::*;

   logic [7:0]    inv_alpha;
   logic [1:0]    pos_in [3];
   logic [1:0]    pos_ff [3];
   logic [7:0]    img_byte [3];
   logic [15:0]   prod_in [3];
   logic [15:0]   prod_ff [3];
   logic [7:0]    cur_ch_in [3];
   logic [7:0]    cur_ch_ff [3];
   logic [31:0]   img_ff;
   logic          hit_ff;
   logic          valid_ff;
   logic [16:0]   biased [3];
   logic [16:0]   quot [3];
   logic [7:0]    chan [3];
   logic [31:0]   result;

   assign inv_alpha = 8'd255 - in_cur[31:24];

   always_comb begin
      pos_in[0] = in_ctl.ro;
      pos_in[1] = in_ctl.go;
      pos_in[2] = in_ctl.bo;
      for (int k = 0; k < 3; k++) begin
         img_byte[k]  = in_img[8*pos_in[k] +: 8];
         prod_in[k]   = {8'd0, img_byte[k]} * {8'd0, inv_alpha};
         cur_ch_in[k] = in_cur[23-8*k -: 8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < 3; k++) begin
            prod_ff[k]   <= prod_in[k];
            cur_ch_ff[k] <= cur_ch_in[k];
            pos_ff[k]    <= pos_in[k];
         end
         img_ff <= in_img;
         hit_ff <= in_ctl.hit;
      end
   end

   always_comb begin
      result = img_ff;
      for (int k = 0; k < 3; k++) begin
         biased[k] = {1'b0, prod_ff[k]} + 17'd127;
         quot[k]   = (biased[k] + 17'd1 + (biased[k] >> 8)) >> 8;
         chan[k]   = quot[k][7:0] + cur_ch_ff[k];
         if (hit_ff) begin
            result[8*pos_ff[k] +: 8] = chan[k];
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_hit   = hit_ff;
   assign out_pixel = result;

endmodule

@@ design/cursor_alpha_overlay_unit.sv @@
// Cursor alpha overlay top level: rectangle test, cursor store, blend and output register.
// A blend result moves through the s1, s2, blend and response registers to the ports.
// One item per cycle unless stalled; the single store port sees one access per cycle.
// Loads and blends reach the store in order, so no forwarding is needed.
// Reset clears the pipeline valids and resets the CSRs; store contents stay undefined.
// There is no clearing pass, so the block accepts items right after reset.
module cursor_alpha_overlay_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic [11:0]                     req_cursor_index,
   input  logic [31:0]                     req_cursor_argb,
   input  logic [11:0]                     req_pixel_x,
   input  logic [11:0]                     req_pixel_y,
   input  logic [31:0]                     req_image_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [31:0]                     rsp_out_pixel,
   output logic                            rsp_cursor_hit,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [cao_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cao_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cao_pkg::*;

   logic [COORD_W-1:0] left_x_ff;
   logic [COORD_W-1:0] top_y_ff;
   logic [DIM_W-1:0]   width_ff;
   logic [DIM_W-1:0]   height_ff;
   logic [FMT_W-1:0]   format_ff;

   logic               adv;
   logic               accept;
   logic [13:0]        col_full;
   logic [13:0]        row_full;
   logic               in_rect;
   chan_map_type       fmt_map;
   blend_ctl_type      s1_ctl_in;

   logic               s1_valid_ff;
   logic               s1_cmd_ff;
   logic [ADDR_W-1:0]  s1_index_ff;
   logic [31:0]        s1_argb_ff;
   logic [DIM_W-1:0]   s1_col_ff;
   logic [DIM_W-1:0]   s1_row_ff;
   blend_ctl_type      s1_ctl_ff;
   logic [31:0]        s1_img_ff;

   logic [13:0]        addr_full;
   logic [ADDR_W-1:0]  store_addr;
   logic [31:0]        store_mem [STORE_DEPTH];
   logic [31:0]        store_rdata_ff;

   logic               s2_valid_in;
   logic               s2_valid_ff;
   blend_ctl_type      s2_ctl_ff;
   logic [31:0]        s2_img_ff;

   logic               blend_valid;
   logic               blend_hit;
   logic [31:0]        blend_pixel;

   logic               rsp_valid_ff;
   logic               rsp_cursor_hit_ff;
   logic [31:0]        rsp_out_pixel_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_x_ff <= '0;
         top_y_ff  <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         format_ff <= FMT_PASS;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LEFT_X: left_x_ff <= csr_data[COORD_W-1:0];
            CSR_TOP_Y:  top_y_ff  <= csr_data[COORD_W-1:0];
            CSR_WIDTH:  width_ff  <= csr_data[DIM_W-1:0];
            CSR_HEIGHT: height_ff <= csr_data[DIM_W-1:0];
            CSR_FORMAT: format_ff <= csr_data[FMT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && req_ready;

   always_comb begin
      col_full = {2'b00, req_pixel_x} - {left_x_ff[COORD_W-1], left_x_ff};
      row_full = {2'b00, req_pixel_y} - {top_y_ff[COORD_W-1], top_y_ff};
      in_rect  = !col_full[13] && !row_full[13]
                 && (col_full[12:0] < {6'd0, width_ff})
                 && (row_full[12:0] < {6'd0, height_ff});
      fmt_map  = decode_format(format_ff);
      s1_ctl_in.hit = in_rect && fmt_map.ok;
      s1_ctl_in.ro  = fmt_map.ro;
      s1_ctl_in.go  = fmt_map.go;
      s1_ctl_in.bo  = fmt_map.bo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_cmd_ff   <= req_cmd;
         s1_index_ff <= req_cursor_index[ADDR_W-1:0];
         s1_argb_ff  <= req_cursor_argb;
         s1_col_ff   <= col_full[DIM_W-1:0];
         s1_row_ff   <= row_full[DIM_W-1:0];
         s1_ctl_ff   <= s1_ctl_in;
         s1_img_ff   <= req_image_pixel;
      end
   end

   assign addr_full  = {7'd0, s1_row_ff} * {7'd0, width_ff} + {7'd0, s1_col_ff};
   assign store_addr = (s1_cmd_ff == CMD_LOAD) ? s1_index_ff : addr_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         if (s1_cmd_ff == CMD_LOAD) begin
            store_mem[store_addr] <= s1_argb_ff;
         end else begin
            store_rdata_ff <= store_mem[store_addr];
         end
      end
   end

   assign s2_valid_in = s1_valid_ff && (s1_cmd_ff == CMD_BLEND);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_ctl_ff <= s1_ctl_ff;
         s2_img_ff <= s1_img_ff;
      end
   end

   cao_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (s2_valid_ff),
      .in_ctl    (s2_ctl_ff),
      .in_img    (s2_img_ff),
      .in_cur    (store_rdata_ff),
      .out_valid (blend_valid),
      .out_hit   (blend_hit),
      .out_pixel (blend_pixel)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= blend_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_cursor_hit_ff <= blend_hit;
         rsp_out_pixel_ff  <= blend_pixel;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_hit = rsp_cursor_hit_ff;
   assign rsp_out_pixel  = rsp_out_pixel_ff;

   a_hit_needs_format: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_cursor_hit_ff |-> format_ff != FMT_PASS && format_ff != FMT_RSVD)
      else $error("cursor hit reported for an unsupported pixel format");

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !s1_valid_ff && !s2_valid_ff)
      else $error("pipeline holds valid data right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled while the output register is empty");

   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      adv && s1_valid_ff && s1_cmd_ff == CMD_LOAD |=> !s2_valid_ff)
      else $error("cursor load transfer entered the blend stages");

endmodule
